// ----- sv/litp_pkg.sv -----
// Shared types, codes and helpers for the infix-to-postfix converter.
package litp_pkg;

    // Sizes
    localparam int STACK_DEPTH = 32;
    localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int VAR_ID_BITS = 16;
    localparam int FQ_DEPTH    = 2;   // token queue, power of two
    localparam int FQ_IDX_W    = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W    = $clog2(FQ_DEPTH + 1);
    localparam int OQ_DEPTH    = 4;   // result queue, power of two
    localparam int OQ_IDX_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

    // Input token kinds
    localparam logic [1:0] TK_VAR    = 2'd0;
    localparam logic [1:0] TK_LPAREN = 2'd1;
    localparam logic [1:0] TK_RPAREN = 2'd2;
    localparam logic [1:0] TK_OPER   = 2'd3;

    // Operator codes; LP_MARK tags a left paren on the stack
    localparam logic [2:0] OP_NOT    = 3'd0;
    localparam logic [2:0] OP_AND    = 3'd1;
    localparam logic [2:0] OP_OR     = 3'd2;
    localparam logic [2:0] OP_IMPL   = 3'd3;
    localparam logic [2:0] OP_BICOND = 3'd4;
    localparam logic [2:0] LP_MARK   = 3'd7;

    // Result kinds
    localparam logic [1:0] RK_VAR   = 2'd0;
    localparam logic [1:0] RK_OPER  = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_BAD_START     = 4'd0;
    localparam logic [3:0] ERR_BINARY_START  = 4'd1;
    localparam logic [3:0] ERR_BAD_END       = 4'd2;
    localparam logic [3:0] ERR_VAR_AFTER_VAR = 4'd3;
    localparam logic [3:0] ERR_VAR_AFTER_RP  = 4'd4;
    localparam logic [3:0] ERR_BAD_LPAREN    = 4'd5;
    localparam logic [3:0] ERR_BAD_RPAREN    = 4'd6;
    localparam logic [3:0] ERR_OP_AFTER_OP   = 4'd7;
    localparam logic [3:0] ERR_BIN_AFTER_LP  = 4'd8;
    localparam logic [3:0] ERR_MISSING_RP    = 4'd9;
    localparam logic [3:0] ERR_OVERFLOW      = 4'd10;
    localparam logic [3:0] ERR_UNMATCHED_RP  = 4'd11;

    // Classified token word
    typedef struct packed {
        logic [1:0]             kind;
        logic [2:0]             oper;
        logic [VAR_ID_BITS-1:0] var_id;
        logic                   last;
    } token_t;

    // Result word
    typedef struct packed {
        logic [1:0]             kind;
        logic [2:0]             oper;
        logic [VAR_ID_BITS-1:0] var_id;
        logic [3:0]             err;
        logic                   eor;
        logic                   eoe;
    } result_t;

    // Binding strength, tighter is larger
    function automatic logic [2:0] prec_of(input logic [2:0] op);
        logic [2:0] p;
        unique case (op)
            OP_NOT:  p = 3'd5;
            OP_AND:  p = 3'd4;
            OP_OR:   p = 3'd3;
            OP_IMPL: p = 3'd2;
            default: p = 3'd1;
        endcase
        return p;
    endfunction

    // True when the stacked operator leaves before the incoming one is pushed
    function automatic logic pops_before(input logic [2:0] incoming,
                                         input logic [2:0] top);
        logic r;
        if (top > OP_BICOND)
            r = 1'b0;
        else if (incoming == OP_NOT || incoming == OP_IMPL)
            r = prec_of(incoming) < prec_of(top);
        else
            r = prec_of(incoming) <= prec_of(top);
        return r;
    endfunction

endpackage

// ----- sv/litp_front.sv -----
// Token intake: classifies operator codes and buffers tokens for the back end.
module litp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        token_kind,
    input  logic [2:0]                        oper_code,
    input  logic [litp_pkg::VAR_ID_BITS-1:0]  var_ident,
    input  logic                              last_token,
    output logic                              tok_valid,
    output litp_pkg::token_t                  tok,
    input  logic                              tok_take
);
    import litp_pkg::*;

    token_t               q_mem [FQ_DEPTH];
    logic [FQ_IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FQ_IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FQ_CNT_W-1:0]  cnt_reg, cnt_next;
    token_t               tok_in;
    logic                 wr_en;
    logic                 rd_en;

    // Classify: out-of-range operator codes act as biconditional
    always_comb
    begin
        tok_in.kind   = token_kind;
        tok_in.oper   = (oper_code > OP_BICOND) ? OP_BICOND : oper_code;
        tok_in.var_id = var_ident;
        tok_in.last   = last_token;
    end

    assign full      = (cnt_reg == FQ_CNT_W'(FQ_DEPTH));
    assign tok_valid = (cnt_reg != '0);
    assign tok       = q_mem[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = tok_take && tok_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + FQ_IDX_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + FQ_IDX_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + FQ_CNT_W'(wr_en) - FQ_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wr_ptr_reg] <= tok_in;
    end

endmodule

// ----- sv/litp_outq.sv -----
// Result queue between the back end and the result ports.
module litp_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  litp_pkg::result_t res_in,
    output logic              res_full,
    output logic              empty,
    input  logic              pop,
    output litp_pkg::result_t res_head
);
    import litp_pkg::*;

    result_t              q_mem [OQ_DEPTH];
    logic [OQ_IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                 wr_en;
    logic                 rd_en;

    assign res_full = (cnt_reg == OQ_CNT_W'(OQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign res_head = q_mem[rd_ptr_reg];
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + OQ_IDX_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + OQ_IDX_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + OQ_CNT_W'(wr_en) - OQ_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wr_ptr_reg] <= res_in;
    end

endmodule

// ----- sv/litp_back.sv -----
// Shunting-yard sequencer: syntax checks, operator stack and result framing.
module litp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  litp_pkg::token_t  tok,
    output logic              tok_take,
    input  logic              res_full,
    output logic              res_push,
    output litp_pkg::result_t res_word
);
    import litp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_POP_RP, S_POP_OP, S_FLUSH, S_FIN} state_t;
    typedef enum logic [2:0] {PK_UNKNOWN, PK_VAR, PK_LPAREN, PK_RPAREN, PK_OPER} prev_t;

    state_t                state_reg, state_next;
    prev_t                 prev_reg, prev_next;
    logic                  disc_reg, disc_next;
    logic                  err_seen_reg, err_seen_next;
    logic [STK_CNT_W-1:0]  cnt_reg, cnt_next;
    token_t                tok_reg, tok_next;
    logic                  pend_valid_reg, pend_valid_next;
    result_t               pend_reg, pend_next;
    logic [2:0]            stack_mem [STACK_DEPTH];

    logic [STK_CNT_W-1:0]  top_pos;
    logic [2:0]            top_val;
    logic                  stk_full;
    logic                  stk_we;
    logic [2:0]            stk_wval;
    logic                  gen_req;
    result_t               gen_word;
    logic                  take_req;
    logic                  push_req;
    logic                  stall;
    logic                  early_err;
    logic [3:0]            early_code;

    function automatic result_t mk_result(input logic [1:0] kind,
                                          input logic [2:0] oper,
                                          input logic [VAR_ID_BITS-1:0] v,
                                          input logic [3:0] err);
        result_t r;
        r.kind   = kind;
        r.oper   = oper;
        r.var_id = v;
        r.err    = err;
        r.eor    = 1'b0;
        r.eoe    = 1'b0;
        return r;
    endfunction

    // Top of stack
    assign top_pos  = cnt_reg - STK_CNT_W'(1);
    assign top_val  = stack_mem[top_pos[STK_IDX_W-1:0]];
    assign stk_full = (cnt_reg >= STK_CNT_W'(STACK_DEPTH));

    // Syntax checks on the incoming token, in reporting order
    always_comb
    begin
        early_err  = 1'b1;
        early_code = ERR_BAD_START;
        priority if (prev_reg == PK_UNKNOWN && tok.kind == TK_RPAREN)
            early_code = ERR_BAD_START;
        else if (prev_reg == PK_UNKNOWN && tok.kind == TK_OPER && tok.oper != OP_NOT)
            early_code = ERR_BINARY_START;
        else if (tok.last && tok.kind != TK_VAR && tok.kind != TK_RPAREN)
            early_code = ERR_BAD_END;
        else if (tok.kind == TK_VAR && prev_reg == PK_VAR)
            early_code = ERR_VAR_AFTER_VAR;
        else if (tok.kind == TK_VAR && prev_reg == PK_RPAREN)
            early_code = ERR_VAR_AFTER_RP;
        else if (tok.kind == TK_LPAREN && prev_reg != PK_OPER &&
                 prev_reg != PK_LPAREN && prev_reg != PK_UNKNOWN)
            early_code = ERR_BAD_LPAREN;
        else if (tok.kind == TK_RPAREN && prev_reg != PK_VAR && prev_reg != PK_RPAREN)
            early_code = ERR_BAD_RPAREN;
        else if (tok.kind == TK_OPER && prev_reg == PK_OPER && tok.oper != OP_NOT)
            early_code = ERR_OP_AFTER_OP;
        else if (tok.kind == TK_OPER && prev_reg == PK_LPAREN && tok.oper != OP_NOT)
            early_code = ERR_BIN_AFTER_LP;
        else
            early_err = 1'b0;
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        prev_next       = prev_reg;
        disc_next       = disc_reg;
        err_seen_next   = err_seen_reg;
        cnt_next        = cnt_reg;
        tok_next        = tok_reg;
        take_req        = 1'b0;
        stk_we          = 1'b0;
        stk_wval        = LP_MARK;
        gen_req         = 1'b0;
        gen_word        = mk_result(RK_ERROR, OP_NOT, '0, ERR_BAD_START);

        unique case (state_reg)
            S_IDLE:
            begin
                if (tok_valid)
                begin
                    take_req = 1'b1;
                    if (disc_reg)
                    begin
                        // dropping tokens until the end of the expression
                        if (tok.last)
                        begin
                            prev_next = PK_UNKNOWN;
                            disc_next = 1'b0;
                            cnt_next  = '0;
                        end
                    end
                    else
                    begin
                        tok_next      = tok;
                        err_seen_next = 1'b0;
                        if (early_err)
                        begin
                            gen_req       = 1'b1;
                            gen_word      = mk_result(RK_ERROR, OP_NOT, '0, early_code);
                            err_seen_next = 1'b1;
                            state_next    = S_FIN;
                        end
                        else
                        begin
                            unique case (tok.kind)
                                TK_VAR:
                                begin
                                    gen_req    = 1'b1;
                                    gen_word   = mk_result(RK_VAR, OP_NOT, tok.var_id,
                                                           ERR_BAD_START);
                                    prev_next  = PK_VAR;
                                    state_next = tok.last ? S_FLUSH : S_FIN;
                                end
                                TK_LPAREN:
                                begin
                                    if (stk_full)
                                    begin
                                        gen_req       = 1'b1;
                                        gen_word      = mk_result(RK_ERROR, OP_NOT, '0,
                                                                  ERR_OVERFLOW);
                                        err_seen_next = 1'b1;
                                    end
                                    else
                                    begin
                                        stk_we    = 1'b1;
                                        stk_wval  = LP_MARK;
                                        cnt_next  = cnt_reg + STK_CNT_W'(1);
                                        prev_next = PK_LPAREN;
                                    end
                                    state_next = S_FIN;
                                end
                                TK_RPAREN: state_next = S_POP_RP;
                                default:   state_next = S_POP_OP;
                            endcase
                        end
                    end
                end
            end

            // Pop down to the matching left paren
            S_POP_RP:
            begin
                if (cnt_reg == '0)
                begin
                    gen_req       = 1'b1;
                    gen_word      = mk_result(RK_ERROR, OP_NOT, '0, ERR_UNMATCHED_RP);
                    err_seen_next = 1'b1;
                    state_next    = S_FIN;
                end
                else if (top_val == LP_MARK)
                begin
                    cnt_next   = top_pos;
                    prev_next  = PK_RPAREN;
                    state_next = tok_reg.last ? S_FLUSH : S_FIN;
                end
                else
                begin
                    gen_req  = 1'b1;
                    gen_word = mk_result(RK_OPER, top_val, '0, ERR_BAD_START);
                    cnt_next = top_pos;
                end
            end

            // Pop tighter operators (equal ones too, except for NOT and IMPL), then push the new one
            S_POP_OP:
            begin
                if (cnt_reg != '0 && pops_before(tok_reg.oper, top_val))
                begin
                    gen_req  = 1'b1;
                    gen_word = mk_result(RK_OPER, top_val, '0, ERR_BAD_START);
                    cnt_next = top_pos;
                end
                else if (stk_full)
                begin
                    gen_req       = 1'b1;
                    gen_word      = mk_result(RK_ERROR, OP_NOT, '0, ERR_OVERFLOW);
                    err_seen_next = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_wval   = tok_reg.oper;
                    cnt_next   = cnt_reg + STK_CNT_W'(1);
                    prev_next  = PK_OPER;
                    state_next = tok_reg.last ? S_FLUSH : S_FIN;
                end
            end

            // Final flush of the stack
            S_FLUSH:
            begin
                if (cnt_reg == '0)
                    state_next = S_FIN;
                else if (top_val == LP_MARK)
                begin
                    gen_req       = 1'b1;
                    gen_word      = mk_result(RK_ERROR, OP_NOT, '0, ERR_MISSING_RP);
                    err_seen_next = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    gen_req  = 1'b1;
                    gen_word = mk_result(RK_OPER, top_val, '0, ERR_BAD_START);
                    cnt_next = top_pos;
                end
            end

            // Close the run: tag the held word, then restart, start dropping or go on
            default:
            begin
                if (tok_reg.last)
                begin
                    prev_next = PK_UNKNOWN;
                    disc_next = 1'b0;
                    cnt_next  = '0;
                end
                else if (err_seen_reg)
                    disc_next = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    // One word is held back so the end-of-run flags can be set on it
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        res_word        = pend_reg;
        if (state_reg == S_FIN)
        begin
            res_word.eor    = 1'b1;
            res_word.eoe    = tok_reg.last;
            pend_valid_next = 1'b0;
        end
        else if (gen_req)
        begin
            pend_next       = gen_word;
            pend_valid_next = 1'b1;
        end
    end

    assign push_req = pend_valid_reg && (gen_req || state_reg == S_FIN);
    assign stall    = push_req && res_full;
    assign res_push = push_req && !res_full;
    assign tok_take = take_req && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_reg       <= PK_UNKNOWN;
            disc_reg       <= 1'b0;
            err_seen_reg   <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            disc_reg       <= disc_next;
            err_seen_reg   <= err_seen_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers and operator stack
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            tok_reg  <= tok_next;
            pend_reg <= pend_next;
            if (stk_we)
                stack_mem[cnt_reg[STK_IDX_W-1:0]] <= stk_wval;
        end
    end

endmodule

// ----- sv/logic_infix_to_postfix.sv -----
// Top level of the propositional-logic infix-to-postfix converter.
// Tokens enter a two-word queue and are worked by a shunting-yard sequencer
// with a 32-entry operator stack; results leave through a four-word queue.
// A variable or left paren passes the sequencer's decode and end-of-run
// commit steps; an operator adds a push step, and a right paren a paren
// match step. Each operator popped by a right paren, an operator or the
// final flush adds a step, and the last token adds a flush check. A token
// that fails the syntax checks passes decode and commit only; tokens
// dropped after an error pass decode alone. The sequencer stalls only
// while the result queue is full. Syntax errors are reported once per
// expression as an error word with end_of_run set; later tokens up to the
// last one are dropped.
module logic_infix_to_postfix (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        token_kind,
    input  logic [2:0]                        oper_code,
    input  logic [litp_pkg::VAR_ID_BITS-1:0]  var_ident,
    input  logic                              last_token,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        out_kind,
    output logic [2:0]                        out_oper,
    output logic [litp_pkg::VAR_ID_BITS-1:0]  out_var,
    output logic [3:0]                        error_code,
    output logic                              end_of_run,
    output logic                              end_of_expr
);
    import litp_pkg::*;

    logic     tok_valid;
    token_t   tok;
    logic     tok_take;
    logic     res_full;
    logic     res_push;
    result_t  res_word;
    result_t  res_head;

    // Token intake
    litp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .token_kind (token_kind),
        .oper_code  (oper_code),
        .var_ident  (var_ident),
        .last_token (last_token),
        .tok_valid  (tok_valid),
        .tok        (tok),
        .tok_take   (tok_take)
    );

    // Stack sequencer
    litp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    // Result queue
    litp_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_word),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_head (res_head)
    );

    assign out_kind    = res_head.kind;
    assign out_oper    = res_head.oper;
    assign out_var     = res_head.var_id;
    assign error_code  = res_head.err;
    assign end_of_run  = res_head.eor;
    assign end_of_expr = res_head.eoe;

endmodule
